// File: hw/rtl/kleb_pkg.sv
// shared constants and types for the keystroke line edit buffer
package kleb_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int KEY_W        = 8;

    localparam logic [KEY_W-1:0] KEY_PREFIX    = 8'd224;
    localparam logic [KEY_W-1:0] KEY_HOME      = 8'd71;
    localparam logic [KEY_W-1:0] KEY_END       = 8'd79;
    localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'd77;
    localparam logic [KEY_W-1:0] KEY_LEFT      = 8'd75;
    localparam logic [KEY_W-1:0] KEY_DELETE    = 8'd83;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 8'd13;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    typedef struct packed {
        logic accept;   // apply the accepted key beat
        logic emit;     // load next line beat into the output register
    } t_cmd;

    typedef struct packed {
        logic is_enter;   // key on the input is a plain enter
        logic emit_final; // beat loaded now closes the line
        logic slot_free;  // output register can take a beat this cycle
    } t_status;

endpackage

// File: hw/rtl/kleb_ctrl.sv
// controller state machine: key beats while idle, line streaming after enter
module kleb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kleb_pkg::t_status i_status,
    output kleb_pkg::t_cmd    o_cmd
);

    kleb_pkg::t_state r_state;
    kleb_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            kleb_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_enter) begin
                        n_state = kleb_pkg::ST_EMIT;
                    end
                end
            end
            kleb_pkg::ST_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_final) begin
                        n_state = kleb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = kleb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kleb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_enter_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.is_enter) |=> (r_state == kleb_pkg::ST_EMIT))
        else $error("enter beat did not start line streaming");

    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kleb_pkg::ST_EMIT) |-> (!o_cmd.accept && !o_ready))
        else $error("key beat taken while streaming a line");

    a_final_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_status.emit_final) |=> (r_state == kleb_pkg::ST_IDLE))
        else $error("controller did not return to idle after final beat");
`endif

endmodule

// File: hw/rtl/kleb_datapath.sv
// datapath: character cells, cursor, length, prefix flag and output register
module kleb_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kleb_pkg::t_cmd              i_cmd,
    input  logic [kleb_pkg::KEY_W-1:0]  i_key,
    output kleb_pkg::t_status           o_status,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [kleb_pkg::KEY_W-1:0]  o_line_char,
    output logic                        o_line_last,
    output logic                        o_line_empty
);

    localparam int LW = kleb_pkg::LEN_W;
    localparam int DEPTH = kleb_pkg::BUFFER_DEPTH;

    logic [kleb_pkg::KEY_W-1:0] r_cell [DEPTH];
    logic [kleb_pkg::KEY_W-1:0] n_cell [DEPTH];

    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_left, n_left;
    logic          r_prefix, n_prefix;

    logic          r_out_valid;
    logic [kleb_pkg::KEY_W-1:0] r_out_char;
    logic          r_out_last;
    logic          r_out_empty;

    logic          do_remove;
    logic [LW-1:0] remove_pos;
    logic          do_write;

    assign o_status.is_enter   = !r_prefix && (i_key == kleb_pkg::KEY_ENTER);
    assign o_status.emit_final = (r_left <= LW'(1));
    assign o_status.slot_free  = !r_out_valid || i_out_ready;

    // edit decode
    always_comb begin
        n_cur      = r_cur;
        n_len      = r_len;
        n_left     = r_left;
        n_prefix   = r_prefix;
        do_remove  = 1'b0;
        remove_pos = r_cur;
        do_write   = 1'b0;
        if (i_cmd.accept) begin
            if (r_prefix) begin
                n_prefix = 1'b0;
                case (i_key)
                    kleb_pkg::KEY_HOME: begin
                        n_cur = '0;
                    end
                    kleb_pkg::KEY_END: begin
                        n_cur = r_len;
                    end
                    kleb_pkg::KEY_RIGHT: begin
                        if (r_cur < r_len) begin
                            n_cur = r_cur + LW'(1);
                        end
                    end
                    kleb_pkg::KEY_LEFT: begin
                        if (r_cur != '0) begin
                            n_cur = r_cur - LW'(1);
                        end
                    end
                    kleb_pkg::KEY_DELETE: begin
                        if (r_cur < r_len) begin
                            do_remove = 1'b1;
                            n_len     = r_len - LW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (i_key)
                    kleb_pkg::KEY_PREFIX: begin
                        n_prefix = 1'b1;
                    end
                    kleb_pkg::KEY_BACKSPACE: begin
                        if (r_cur != '0) begin
                            do_remove  = 1'b1;
                            remove_pos = r_cur - LW'(1);
                            n_cur      = r_cur - LW'(1);
                            n_len      = r_len - LW'(1);
                        end
                    end
                    kleb_pkg::KEY_ENTER: begin
                        n_left = r_len;
                        n_len  = '0;
                        n_cur  = '0;
                    end
                    default: begin
                        if ((r_cur < r_len) || (r_len < LW'(DEPTH))) begin
                            do_write = 1'b1;
                            n_cur    = r_cur + LW'(1);
                            if (r_cur == r_len) begin
                                n_len = r_len + LW'(1);
                            end
                        end
                    end
                endcase
            end
        end else if (i_cmd.emit && (r_left != '0)) begin
            n_left = r_left - LW'(1);
        end
    end

    // each cell takes its right neighbor on a removal at or before its index or on a stream shift
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [LW-1:0] IDX = LW'(i);
        logic [kleb_pkg::KEY_W-1:0] right_val;
        if (i == DEPTH - 1) begin : g_end
            assign right_val = r_cell[i];
        end else begin : g_mid
            assign right_val = r_cell[i+1];
        end
        always_comb begin
            n_cell[i] = r_cell[i];
            if (i_cmd.emit) begin
                n_cell[i] = right_val;
            end else if (do_remove && (IDX >= remove_pos)) begin
                n_cell[i] = right_val;
            end else if (do_write && (IDX == r_cur)) begin
                n_cell[i] = i_key;
            end
        end
        always_ff @(posedge i_clk) begin
            r_cell[i] <= n_cell[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_len       <= '0;
            r_left      <= '0;
            r_prefix    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur    <= n_cur;
            r_len    <= n_len;
            r_left   <= n_left;
            r_prefix <= n_prefix;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_left == '0) begin
                r_out_char  <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
            end else begin
                r_out_char  <= r_cell[0];
                r_out_last  <= (r_left == LW'(1));
                r_out_empty <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_char  = r_out_char;
    assign o_line_last  = r_out_last;
    assign o_line_empty = r_out_empty;

`ifndef NO_ASSERTIONS
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len)
        else $error("cursor beyond line length");

    a_length_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("line length beyond buffer depth");

    a_line_cleared_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_len == '0 && r_cur == '0 && !i_cmd.accept))
        else $error("line not cleared while streaming");
`endif

endmodule

// File: hw/rtl/keystroke_line_edit_buffer.sv
// top level: keystroke line edit buffer, one key beat in, line beats out on enter
// edit keys: one key beat accepted per cycle while idle, state updated at the accepting edge
// enter: the controller moves to the emit state, then line beats are loaded into the output register, one beat
// per cycle while the sink is ready; a line holds input ready low until its final beat is loaded
// (a single empty-line beat if the line is empty), and longer while the sink stalls
// line beats shift out of the character cells, which sets the one beat per cycle rate while the sink is ready
// reset is synchronous active low: clears cursor, length, remaining count, prefix, state, output valid
module keystroke_line_edit_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] key_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] line_char
    output logic       o_m_tlast,   // line_last
    output logic       o_m_tuser    // [0] line_empty
);

    kleb_pkg::t_cmd    cmd;
    kleb_pkg::t_status status;

    kleb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    kleb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key        (i_s_tdata),
        .o_status     (status),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_line_char  (o_m_tdata),
        .o_line_last  (o_m_tlast),
        .o_line_empty (o_m_tuser)
    );

endmodule
